>>> hdl/vbse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbse_pkg
// shared constants, types and hash helpers of the spread estimator
// ----------------------------------------------------------------------------
package vbse_pkg;

  localparam int unsigned BitmapBitsDef  = 1048576;
  localparam int unsigned VirtualSizeDef = 8192;
  localparam int unsigned LogItersQ24    = 24;
  localparam logic [31:0] Ln2Q32         = 32'd2977044472;

  localparam logic [31:0] MmC1   = 32'hcc9e2d51;
  localparam logic [31:0] MmC2   = 32'h1b873593;
  localparam logic [31:0] MmAdd  = 32'he6546b64;
  localparam logic [31:0] MmF1   = 32'h85ebca6b;
  localparam logic [31:0] MmF2   = 32'hc2b2ae35;

  localparam logic [0:0] CmdUpdate = 1'b0;
  localparam logic [0:0] CmdQuery  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_H5,
    ST_H6,
    ST_H7,
    ST_H8,
    ST_RD,
    ST_CHK,
    ST_LNSEL,
    ST_LNNORM,
    ST_LNSQ,
    ST_LNMUL,
    ST_LNACC,
    ST_EST,
    ST_OUT
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
    rotl = (x << r) | (x >> (6'd32 - {1'b0, r}));
  endfunction

endpackage

>>> hdl/virtual_bitmap_spread_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_bitmap_spread_estimator_top
// compact spread estimator: one shared bitmap, per-flow virtual positions
// ----------------------------------------------------------------------------
// channel  | signals                                          | dir
// in       | in_valid_i in_ready_o command_i flow_key_i ...   | request in
// out      | out_valid_o out_ready_i spread_estimate_o ...    | result out
// cfg      | psel penable pwrite paddr pwdata prdata pready   | apb
// update: two six-step hashes on one
// shared 32x32 multiplier, then a read and, if the bit was clear, a write back
// query: per virtual position a hash, a read and a check, then four logs
// on the shared multiplier and the estimate, before the result is valid
// after reset a clearing pass writes zero to every word of the bitmap memory
// the bitmap is a 32-bit wide memory with one read-modify-write port
// a result waiting in the output register blocks the next request
// ----------------------------------------------------------------------------
module virtual_bitmap_spread_estimator_top #(
  parameter int unsigned BitmapBits  = vbse_pkg::BitmapBitsDef,
  parameter int unsigned VirtualSize = vbse_pkg::VirtualSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [31:0] flow_key_i,
  input  logic [31:0] element_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] spread_estimate_o,
  output logic [13:0] virtual_zero_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned BitW   = $clog2(BitmapBits);
  localparam int unsigned Words  = (BitmapBits + 31) / 32;
  localparam int unsigned WordW  = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned VposW  = $clog2(VirtualSize);
  localparam int unsigned CntW   = BitW + 1;
  localparam int unsigned ZW     = VposW + 1;

  vbse_pkg::state_e state_q, state_d;

  logic [31:0]     seed_q;
  logic            cmd_q;
  logic [31:0]     key_q;
  logic [31:0]     h_q, h_d, k_q, k_d;
  logic [31:0]     hseed_q, hseed_d;
  logic            second_q, second_d;
  logic [ZW-1:0]   vcnt_q, vcnt_d;
  logic [ZW-1:0]   z_q, z_d;
  logic [CntW-1:0] zleft_q, zleft_d;
  logic [WordW-1:0] clr_q, clr_d;
  logic [BitW-1:0] idx_q, idx_d;
  logic [1:0]      lsel_q, lsel_d;
  logic [63:0]     y_q, y_d;
  logic [28:0]     lg_q, lg_d;
  logic [4:0]      it_q, it_d;
  logic signed [25:0] dacc_q, dacc_d;
  logic            ovalid_q, ovalid_d;
  logic [31:0]     est_q, est_d;
  logic [13:0]     zo_q, zo_d;

  logic [31:0] mem [Words];
  logic [31:0] rdata_q;
  logic        mem_we;
  logic [WordW-1:0] mem_addr;
  logic [31:0] mem_wdata;

  // shared multiplier
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  assign mprod = {32'd0, ma} * {32'd0, mb};

  logic cfg_we;
  assign cfg_we = psel & penable & pwrite & (paddr == 2'd0);
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we) begin
      seed_q <= pwdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  logic [31:0] x_sel;
  logic [4:0]  lz_n;
  logic [60:0] lnprod;
  logic [20:0] lnq;

  always_comb begin
    case (lsel_q)
      2'd0:    x_sel = {{(32-CntW){1'b0}}, zleft_q};
      2'd1:    x_sel = BitmapBits;
      2'd2:    x_sel = {{(32-ZW){1'b0}}, z_q};
      default: x_sel = VirtualSize;
    endcase
    if (x_sel == 32'd0) x_sel = 32'd1;
    lz_n = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (x_sel[b]) lz_n = 5'(b);
    end
    lnprod = mprod[60:0] + 61'(64'd1 << 39);
    lnq = lnprod[60:40];
  end

  always_comb begin
    state_d   = state_q;
    h_d = h_q; k_d = k_q; hseed_d = hseed_q; second_d = second_q;
    vcnt_d = vcnt_q; z_d = z_q; zleft_d = zleft_q; clr_d = clr_q;
    idx_d = idx_q; lsel_d = lsel_q; y_d = y_q; lg_d = lg_q; it_d = it_q;
    dacc_d = dacc_q; ovalid_d = ovalid_q; est_d = est_q; zo_d = zo_q;
    ma = k_q; mb = vbse_pkg::MmC1;
    mem_we = 1'b0; mem_addr = idx_q[BitW-1:5]; mem_wdata = rdata_q;
    in_ready_o = 1'b0;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      vbse_pkg::ST_CLEAR: begin
        mem_we = 1'b1; mem_addr = clr_q; mem_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == WordW'(Words - 1)) state_d = vbse_pkg::ST_IDLE;
      end
      vbse_pkg::ST_IDLE: begin
        in_ready_o = !ovalid_q;
        if (in_valid_i && !ovalid_q) begin
          second_d = 1'b0;
          vcnt_d = '0; z_d = '0;
          if (command_i == vbse_pkg::CmdUpdate) begin
            k_d = element_id_i; hseed_d = seed_q;
          end else begin
            k_d = flow_key_i; hseed_d = 32'd0;
          end
          state_d = vbse_pkg::ST_H1;
        end
      end
      vbse_pkg::ST_H1: begin
        ma = k_q; mb = vbse_pkg::MmC1;
        k_d = vbse_pkg::rotl(mprod[31:0], 5'd15);
        state_d = vbse_pkg::ST_H2;
      end
      vbse_pkg::ST_H2: begin
        ma = k_q; mb = vbse_pkg::MmC2;
        h_d = vbse_pkg::rotl(hseed_q ^ mprod[31:0], 5'd13);
        state_d = vbse_pkg::ST_H3;
      end
      vbse_pkg::ST_H3: begin
        ma = h_q; mb = 32'd5;
        h_d = (mprod[31:0] + vbse_pkg::MmAdd) ^ 32'd4;
        h_d = h_d ^ (h_d >> 16);
        state_d = vbse_pkg::ST_H4;
      end
      vbse_pkg::ST_H4: begin
        ma = h_q; mb = vbse_pkg::MmF1;
        h_d = mprod[31:0] ^ (mprod[31:0] >> 13);
        state_d = vbse_pkg::ST_H5;
      end
      vbse_pkg::ST_H5: begin
        ma = h_q; mb = vbse_pkg::MmF2;
        h_d = mprod[31:0] ^ (mprod[31:0] >> 16);
        state_d = vbse_pkg::ST_H6;
      end
      vbse_pkg::ST_H6: begin
        if (cmd_q == vbse_pkg::CmdUpdate && !second_q) begin
          second_d = 1'b1;
          k_d = key_q;
          hseed_d = {{(32-VposW){1'b0}}, h_q[VposW-1:0]};
          state_d = vbse_pkg::ST_H1;
        end else begin
          idx_d = h_q[BitW-1:0];
          state_d = vbse_pkg::ST_RD;
        end
      end
      vbse_pkg::ST_RD: begin
        mem_addr = idx_q[BitW-1:5];
        state_d = vbse_pkg::ST_CHK;
      end
      vbse_pkg::ST_CHK: begin
        if (cmd_q == vbse_pkg::CmdUpdate) begin
          if (!rdata_q[idx_q[4:0]]) begin
            mem_we = 1'b1;
            mem_wdata = rdata_q | (32'd1 << idx_q[4:0]);
            if (zleft_q != '0) zleft_d = zleft_q - 1'b1;
          end
          state_d = vbse_pkg::ST_IDLE;
        end else begin
          if (!rdata_q[idx_q[4:0]]) z_d = z_q + 1'b1;
          if (vcnt_q == ZW'(VirtualSize - 1)) begin
            lsel_d = 2'd0; dacc_d = '0;
            state_d = vbse_pkg::ST_LNNORM;
          end else begin
            vcnt_d = vcnt_q + 1'b1;
            k_d = key_q;
            hseed_d = {{(32-ZW){1'b0}}, vcnt_q + 1'b1};
            state_d = vbse_pkg::ST_H1;
          end
        end
      end
      vbse_pkg::ST_LNNORM: begin
        y_d = {32'd0, x_sel} << (5'd31 - lz_n);
        lg_d = {lz_n, 24'd0};
        it_d = 5'd23;
        state_d = vbse_pkg::ST_LNSQ;
      end
      vbse_pkg::ST_LNSQ: begin
        ma = y_q[31:0]; mb = y_q[31:0];
        y_d = mprod >> 31;
        if (y_d >= 64'h1_0000_0000) begin
          y_d = y_d >> 1;
          lg_d = lg_q | (29'd1 << it_q);
        end
        if (it_q == 5'd0) state_d = vbse_pkg::ST_LNACC;
        else it_d = it_q - 1'b1;
      end
      vbse_pkg::ST_LNACC: begin
        ma = {3'd0, lg_q}; mb = vbse_pkg::Ln2Q32;
        if (lsel_q == 2'd0 || lsel_q == 2'd3)
          dacc_d = dacc_q + 26'(signed'({5'd0, lnq}));
        else
          dacc_d = dacc_q - 26'(signed'({5'd0, lnq}));
        lsel_d = lsel_q + 1'b1;
        if (lsel_q == 2'd3) state_d = vbse_pkg::ST_EST;
        else state_d = vbse_pkg::ST_LNNORM;
      end
      vbse_pkg::ST_EST: begin
        ma = 32'(VirtualSize); mb = {6'd0, dacc_q[25:0]};
        if (dacc_q <= 0) est_d = '0;
        else if (mprod[63:48] != 16'd0) est_d = 32'hFFFF_FFFF;
        else est_d = mprod[47:16];
        zo_d = 14'(z_q);
        ovalid_d = 1'b1;
        state_d = vbse_pkg::ST_IDLE;
      end
      default: state_d = vbse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vbse_pkg::ST_CLEAR;
      clr_q    <= '0;
      zleft_q  <= CntW'(BitmapBits);
      ovalid_q <= 1'b0;
      cmd_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      zleft_q  <= zleft_d;
      ovalid_q <= ovalid_d;
      if (in_valid_i && in_ready_o) cmd_q <= command_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      key_q <= flow_key_i;
    end
    h_q <= h_d; k_q <= k_d; hseed_q <= hseed_d; second_q <= second_d;
    vcnt_q <= vcnt_d; z_q <= z_d; idx_q <= idx_d; lsel_q <= lsel_d;
    y_q <= y_d; lg_q <= lg_d; it_q <= it_d; dacc_q <= dacc_d;
    est_q <= est_d; zo_q <= zo_d;
  end

  assign out_valid_o          = ovalid_q;
  assign spread_estimate_o    = est_q;
  assign virtual_zero_count_o = zo_q;

endmodule

>>> sim/tb_virtual_bitmap_spread_estimator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_virtual_bitmap_spread_estimator_top
// self-checking bench for the spread estimator: a scoreboard keeps its own
// bitmap and zero count, predicts each query result and compares the
// estimate and the virtual zero count; updates, hot-key bursts, heavily set
// keys and random noise run under several hash seeds with random stalls
// ----------------------------------------------------------------------------
module tb_virtual_bitmap_spread_estimator_top;

  localparam int unsigned BBITS      = vbse_pkg::BitmapBitsDef;
  localparam int unsigned VSIZE      = vbse_pkg::VirtualSizeDef;
  localparam logic [1:0]  RegHashSeed = 2'd0;
  localparam int          LIMIT      = 400000000;
  localparam int          DRAIN      = 64;
  localparam int unsigned FILL       = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        command_i = vbse_pkg::CmdUpdate;
  logic [31:0] flow_key_i = '0;
  logic [31:0] element_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [31:0] spread_estimate_o;
  logic [13:0] virtual_zero_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  cycles = 0;
  int  sent = 0;
  bit  calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  virtual_bitmap_spread_estimator_top #(
    .BitmapBits (BBITS),
    .VirtualSize(VSIZE)
  ) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .command_i, .flow_key_i,
    .element_id_i, .out_valid_o, .out_ready_i, .spread_estimate_o,
    .virtual_zero_count_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  typedef struct packed {
    logic [31:0] estimate;
    logic [13:0] zeros;
  } spread_result_t;

  class spread_scoreboard;
    bit             bitmap[BBITS];
    int unsigned    zero_bits;
    logic [31:0]    seed;
    spread_result_t expected_spreads[$];
    int             fail_count;

    function new();
      zero_bits  = BBITS;
      seed       = '0;
      fail_count = 0;
    endfunction

    function logic [31:0] murmur(logic [31:0] data, logic [31:0] hseed);
      logic [31:0] k;
      logic [31:0] h;
      k = data * vbse_pkg::MmC1;
      k = {k[16:0], k[31:17]};
      k = k * vbse_pkg::MmC2;
      h = hseed ^ k;
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + vbse_pkg::MmAdd;
      h = h ^ 32'd4;
      h = h ^ (h >> 16);
      h = h * vbse_pkg::MmF1;
      h = h ^ (h >> 13);
      h = h * vbse_pkg::MmF2;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function int unsigned element_slot(logic [31:0] elem);
      return murmur(elem, seed) % VSIZE;
    endfunction

    // natural log in q16 via log2 with a 24-bit fraction
    function longint ln_q16(int unsigned x);
      int unsigned       n;
      longint unsigned   y;
      longint unsigned   lg;
      n = 0;
      if (x == 0) x = 1;
      while (n < 31 && (x >> (n + 1)) != 0) n++;
      y  = longint'(x) << (31 - n);
      lg = longint'(n) << 24;
      for (int i = 23; i >= 0; i--) begin
        y = (y * y) >> 31;
        if (y >= 64'h1_0000_0000) begin
          y  = y >> 1;
          lg = lg | (64'd1 << i);
        end
      end
      return longint'((lg * 64'd2977044472 + (64'd1 << 39)) >> 40);
    endfunction

    function void note_request(logic cmd, logic [31:0] key, logic [31:0] elem);
      int unsigned     pos;
      int unsigned     idx;
      int unsigned     z;
      longint          d;
      longint unsigned e;
      spread_result_t  r;
      if (cmd == vbse_pkg::CmdUpdate) begin
        pos = element_slot(elem);
        idx = murmur(key, pos) % BBITS;
        if (!bitmap[idx]) begin
          bitmap[idx] = 1'b1;
          if (zero_bits > 0) zero_bits--;
        end
      end else begin
        z = 0;
        for (int unsigned i = 0; i < VSIZE; i++) begin
          idx = murmur(key, i) % BBITS;
          if (!bitmap[idx]) z++;
        end
        d = ln_q16(zero_bits) - ln_q16(BBITS) - ln_q16(z) + ln_q16(VSIZE);
        e = 0;
        if (d > 0) begin
          e = (longint'(VSIZE) * d) >> 16;
          if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
        end
        r.estimate = e[31:0];
        r.zeros    = z[13:0];
        expected_spreads.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
    endtask

    task check_result(logic [31:0] est, logic [13:0] zc);
      spread_result_t r;
      if (expected_spreads.size() == 0) begin
        report_mismatch($sformatf("unexpected result est=%0d zeros=%0d", est, zc));
      end else begin
        r = expected_spreads.pop_front();
        if (est !== r.estimate)
          report_mismatch($sformatf("spread_estimate %0d, want %0d", est, r.estimate));
        if (zc !== r.zeros)
          report_mismatch($sformatf("virtual_zero_count %0d, want %0d", zc, r.zeros));
      end
    endtask
  endclass

  spread_scoreboard sb = new();

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(spread_estimate_o, virtual_zero_count_o);
  end

  // result side stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  task send_request(logic cmd, logic [31:0] key, logic [31:0] elem);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    flow_key_i   <= key;
    element_id_i <= elem;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(cmd, key, elem);
    sent++;
  endtask

  task write_seed(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RegHashSeed;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.seed = value;
  endtask

  task wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_spreads.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // many distinct virtual positions of the key get set, then query it
  task automatic fill_key(logic [31:0] key);
    bit          covered[VSIZE];
    int unsigned left;
    int unsigned s;
    logic [31:0] e;
    left = FILL;
    for (int t = 0; t < 5000 && left > 0; t++) begin
      e = $urandom;
      s = sb.element_slot(e);
      if (!covered[s]) begin
        covered[s] = 1'b1;
        left--;
        send_request(vbse_pkg::CmdUpdate, key, e);
      end
    end
    send_request(vbse_pkg::CmdQuery, key, $urandom);
  endtask

  task random_phase(int count, bit last);
    logic [31:0] hot_keys[8];
    int          stop;
    int          pick;
    logic [31:0] k;
    stop = sent + count;
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    while (sent < stop) begin
      if (last && stop - sent < 150) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        fill_key($urandom);
      end else if (pick < 70) begin
        k = hot_keys[$urandom_range(0, 7)];
        repeat ($urandom_range(1, 20)) send_request(vbse_pkg::CmdUpdate, k, $urandom);
        send_request(vbse_pkg::CmdQuery, k, $urandom);
      end else begin
        send_request(1'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // bitmap clearing pass after reset
    repeat (BBITS / 32 + DRAIN) @(posedge clk_i);
    write_seed(32'h0);

    send_request(vbse_pkg::CmdQuery, 32'h0, 32'h0);
    send_request(vbse_pkg::CmdQuery, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(vbse_pkg::CmdUpdate, 32'h0, 32'h0);
    send_request(vbse_pkg::CmdUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(vbse_pkg::CmdUpdate, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(vbse_pkg::CmdUpdate, 32'h0, 32'hFFFF_FFFF);
    send_request(vbse_pkg::CmdQuery, 32'h0, 32'h1234_5678);
    send_request(vbse_pkg::CmdQuery, 32'hFFFF_FFFF, 32'h0);
    send_request(vbse_pkg::CmdUpdate, 32'h8000_0001, 32'h7FFF_FFFE);
    send_request(vbse_pkg::CmdQuery, 32'h8000_0001, 32'h0);
    wait_idle();

    write_seed(32'hFFFF_FFFF);
    random_phase(360, 1'b0);
    wait_idle();
    write_seed($urandom);
    random_phase(360, 1'b0);
    wait_idle();
    write_seed(32'h0000_0001);
    random_phase(360, 1'b0);
    wait_idle();
    write_seed($urandom);
    random_phase(360, 1'b1);
    wait_idle();

    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
